@@ rtl/core/mtfc_pkg.sv @@
`timescale 1ns / 1ps

package mtfc_pkg;

    // Sizes of the stream and history words
    localparam int unsigned HISTORY_DEPTH = 1024;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned HIST_W        = 24;
    localparam int unsigned GAIN_W        = 16;
    localparam int unsigned DELAY_W       = 10;
    localparam int unsigned FRAC_W        = 15;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [DELAY_W-1:0] MAIN_DELAY_RST = 10'd1023;

    // Datapath widths
    localparam int unsigned NUM_TAPS = 4;
    localparam int unsigned TAP_W    = 2;
    localparam int unsigned PROD_W   = GAIN_W + HIST_W;   // gain * past
    localparam int unsigned FB_W     = PROD_W - FRAC_W;   // scaled feedback
    localparam int unsigned PRE_W    = FB_W + 1;          // sample + feedback
    localparam int unsigned TERM_W   = PRE_W - 2;         // after the shift by two
    localparam int unsigned ACC_W    = TERM_W + TAP_W;    // sum of four terms

    // Item sequencing
    localparam int unsigned ITEM_CYCLES     = 7;
    localparam int unsigned PHASE_W         = 3;
    localparam int unsigned OUT_SLOTS       = 2;
    localparam int unsigned MAX_OUTSTANDING = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAIN_DELAY = 3'd0,
        REG_GAIN_MAIN  = 3'd1,
        REG_GAIN_TAP1  = 3'd2,
        REG_GAIN_TAP2  = 3'd3,
        REG_GAIN_TAP3  = 3'd4,
        REG_DELAY_TAP1 = 3'd5,
        REG_DELAY_TAP2 = 3'd6,
        REG_DELAY_TAP3 = 3'd7
    } cfg_reg_t;

    typedef enum logic [TAP_W-1:0] {
        TAP_MAIN  = 2'd0,
        TAP_ONE   = 2'd1,
        TAP_TWO   = 2'd2,
        TAP_THREE = 2'd3
    } tap_t;

    // Control that travels with one history read
    typedef struct packed {
        logic vld;
        tap_t tap;
        logic hit;   // entry holds a produced output
        logic fwd;   // entry is the previous output, not yet in the memory
    } rd_ctl_t;

    // Clamp the accumulated sum to the signed history width
    function automatic logic [HIST_W-1:0] saturate(input logic [ACC_W-1:0] v);
        if (v[ACC_W-1:HIST_W-1] == '0 || v[ACC_W-1:HIST_W-1] == '1) begin
            return v[HIST_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            return {1'b0, {(HIST_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/core/mtfc_ram.sv @@
`timescale 1ns / 1ps

module mtfc_ram #(
    parameter int unsigned WIDTH = mtfc_pkg::HIST_W,
    parameter int unsigned DEPTH = mtfc_pkg::HISTORY_DEPTH,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/multi_tap_feedback_comb_core.sv @@
`timescale 1ns / 1ps

// Multi-tap feedback comb filter over a stream of signed 16-bit samples.
// Input words arrive on s_tvalid/s_tready/s_tdata, one sample per word; each
// produces exactly one output word on m_tvalid/m_tready/m_tdata, in order.
// Tap gains and delays are written through cfg_wr_en/cfg_wr_index/cfg_wr_data;
// the user must write them only while the stream is idle, which the block does
// not enforce. A write lands at the clock edge it is presented. While busy,
// the block starts a new word only as the current one reaches its last phase.
// The limit is the feedback loop through the most recent output: four history
// reads on the single memory read port, then multiply, scale, accumulate and
// saturate before the next word may use that output. A one-word input buffer
// takes the next word while the current one is in work; s_tready then drops
// until that word starts, so a steady stream is paced by the word sequencer.
// The output side holds two words; when the receiver stalls, finished words
// wait there and the block stops starting new words until a slot frees.
// Reset (aresetn low at a clock edge) empties all buffers, restores the
// register defaults and marks the whole history as empty through a fill count,
// so reads of never-written history give zero without a clearing pass.
module multi_tap_feedback_comb_core #(
    parameter int unsigned HISTORY_DEPTH = mtfc_pkg::HISTORY_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mtfc_pkg::SAMPLE_W-1:0]       s_tdata,      // [15:0] in_sample
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mtfc_pkg::SAMPLE_W-1:0]       m_tdata,      // [15:0] out_sample
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [mtfc_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [mtfc_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    localparam int unsigned SAMPLE_W = mtfc_pkg::SAMPLE_W;
    localparam int unsigned HIST_W   = mtfc_pkg::HIST_W;
    localparam int unsigned GAIN_W   = mtfc_pkg::GAIN_W;
    localparam int unsigned DELAY_W  = mtfc_pkg::DELAY_W;
    localparam int unsigned PROD_W   = mtfc_pkg::PROD_W;
    localparam int unsigned FB_W     = mtfc_pkg::FB_W;
    localparam int unsigned PRE_W    = mtfc_pkg::PRE_W;
    localparam int unsigned TERM_W   = mtfc_pkg::TERM_W;
    localparam int unsigned ACC_W    = mtfc_pkg::ACC_W;
    localparam int unsigned FRAC_W   = mtfc_pkg::FRAC_W;
    localparam int unsigned PHASE_W  = mtfc_pkg::PHASE_W;

    localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned K_W    = DELAY_W + 1;
    localparam int unsigned CALC_W = ((FILL_W > K_W) ? FILL_W : K_W) + 1;
    localparam int unsigned OCC_W  = 3;

    localparam logic [CALC_W-1:0]  DEPTH_C    = CALC_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0]   SLOT_LAST  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(HISTORY_DEPTH);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(mtfc_pkg::ITEM_CYCLES - 1);
    localparam logic [PHASE_W-1:0] PHASE_RDS  = PHASE_W'(mtfc_pkg::NUM_TAPS);
    localparam logic [PROD_W-1:0]  FB_BIAS    = PROD_W'((1 << FRAC_W) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [DELAY_W-1:0] main_delay_reg;
    logic        [DELAY_W-1:0] delay_tap1_reg;
    logic        [DELAY_W-1:0] delay_tap2_reg;
    logic        [DELAY_W-1:0] delay_tap3_reg;
    logic signed [GAIN_W-1:0]  gain_main_reg;
    logic signed [GAIN_W-1:0]  gain_tap1_reg;
    logic signed [GAIN_W-1:0]  gain_tap2_reg;
    logic signed [GAIN_W-1:0]  gain_tap3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_delay_reg <= mtfc_pkg::MAIN_DELAY_RST;
            delay_tap1_reg <= '0;
            delay_tap2_reg <= '0;
            delay_tap3_reg <= '0;
            gain_main_reg  <= '0;
            gain_tap1_reg  <= '0;
            gain_tap2_reg  <= '0;
            gain_tap3_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (mtfc_pkg::cfg_reg_t'(cfg_wr_index))
                mtfc_pkg::REG_MAIN_DELAY: main_delay_reg <= cfg_wr_data[DELAY_W-1:0];
                mtfc_pkg::REG_GAIN_MAIN:  gain_main_reg  <= cfg_wr_data[GAIN_W-1:0];
                mtfc_pkg::REG_GAIN_TAP1:  gain_tap1_reg  <= cfg_wr_data[GAIN_W-1:0];
                mtfc_pkg::REG_GAIN_TAP2:  gain_tap2_reg  <= cfg_wr_data[GAIN_W-1:0];
                mtfc_pkg::REG_GAIN_TAP3:  gain_tap3_reg  <= cfg_wr_data[GAIN_W-1:0];
                mtfc_pkg::REG_DELAY_TAP1: delay_tap1_reg <= cfg_wr_data[DELAY_W-1:0];
                mtfc_pkg::REG_DELAY_TAP2: delay_tap2_reg <= cfg_wr_data[DELAY_W-1:0];
                mtfc_pkg::REG_DELAY_TAP3: delay_tap3_reg <= cfg_wr_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input buffer and word sequencer
    // ------------------------------------------------------------------
    logic                hold_vld_reg;
    logic [SAMPLE_W-1:0] hold_data_reg;
    logic                busy_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [1:0]          pend_cnt_reg;   // words started, not yet committed
    logic [1:0]          ob_cnt_reg;     // words held in the output buffer
    logic [PTR_W-1:0]    next_slot_reg;
    logic [FILL_W-1:0]   started_reg;
    logic [PTR_W-1:0]    cur_slot_reg;
    logic [FILL_W-1:0]   cur_fill_reg;
    logic [SAMPLE_W-1:0] cur_sample_reg;

    logic             s_acc;
    logic             pop;
    logic             commit;
    logic             start;
    logic [OCC_W-1:0] occ;
    logic [1:0]       pend_cnt_next;

    assign s_tready = !hold_vld_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    // Start a word only when its result is sure to find an output slot
    assign occ   = OCC_W'(ob_cnt_reg) + OCC_W'(pend_cnt_reg) - OCC_W'(pop);
    assign start = hold_vld_reg && (!busy_reg || phase_reg == PHASE_LAST)
                   && (occ < OCC_W'(mtfc_pkg::OUT_SLOTS));

    always_comb begin
        pend_cnt_next = pend_cnt_reg;
        if (start && !commit) begin
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end else if (commit && !start) begin
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            pend_cnt_reg  <= '0;
            next_slot_reg <= '0;
            started_reg   <= '0;
            cur_slot_reg  <= '0;
            cur_fill_reg  <= '0;
        end else begin
            pend_cnt_reg <= pend_cnt_next;
            if (s_acc) begin
                hold_vld_reg <= 1'b1;
            end else if (start) begin
                hold_vld_reg <= 1'b0;
            end
            if (start) begin
                busy_reg      <= 1'b1;
                phase_reg     <= '0;
                cur_slot_reg  <= next_slot_reg;
                cur_fill_reg  <= started_reg;
                next_slot_reg <= (next_slot_reg == SLOT_LAST) ? '0
                                                              : next_slot_reg + PTR_W'(1);
                if (started_reg != FILL_FULL) begin
                    started_reg <= started_reg + FILL_W'(1);
                end
            end else if (busy_reg) begin
                if (phase_reg == PHASE_LAST) begin
                    busy_reg <= 1'b0;
                end else begin
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            hold_data_reg <= s_tdata;
        end
        if (start) begin
            cur_sample_reg <= hold_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // Read issue: one tap per cycle in the first four phases
    // ------------------------------------------------------------------
    mtfc_pkg::tap_t    iss_tap;
    logic              iss_active;
    logic [K_W-1:0]    iss_k;
    logic              iss_over;
    logic              iss_hit;
    logic              iss_fwd;
    logic [CALC_W-1:0] iss_k_c;
    logic [CALC_W-1:0] slot_c;
    logic [CALC_W-1:0] back_c;
    logic [PTR_W-1:0]  rd_addr;

    assign iss_tap    = mtfc_pkg::tap_t'(phase_reg[mtfc_pkg::TAP_W-1:0]);
    assign iss_active = busy_reg && (phase_reg < PHASE_RDS);

    // Distance back in outputs; a tap set beyond the main delay reads zero
    always_comb begin
        iss_over = 1'b0;
        case (iss_tap)
            mtfc_pkg::TAP_MAIN: begin
                iss_k = {1'b0, main_delay_reg};
            end
            mtfc_pkg::TAP_ONE: begin
                iss_k    = {1'b0, delay_tap1_reg} + K_W'(1);
                iss_over = delay_tap1_reg > main_delay_reg;
            end
            mtfc_pkg::TAP_TWO: begin
                iss_k    = {1'b0, delay_tap2_reg} + K_W'(1);
                iss_over = delay_tap2_reg > main_delay_reg;
            end
            mtfc_pkg::TAP_THREE: begin
                iss_k    = {1'b0, delay_tap3_reg} + K_W'(1);
                iss_over = delay_tap3_reg > main_delay_reg;
            end
            default: begin
                iss_k = '0;
            end
        endcase
    end

    assign iss_k_c = CALC_W'(iss_k);
    assign slot_c  = CALC_W'(cur_slot_reg);
    assign iss_hit = (iss_k != '0) && !iss_over && (iss_k_c <= CALC_W'(cur_fill_reg));
    assign iss_fwd = iss_hit && (iss_k == K_W'(1));
    assign back_c  = (iss_k_c <= slot_c) ? (slot_c - iss_k_c) : (slot_c + DEPTH_C - iss_k_c);
    assign rd_addr = iss_hit ? back_c[PTR_W-1:0] : '0;

    // ------------------------------------------------------------------
    // History memory
    // ------------------------------------------------------------------
    logic              cmt_reg;
    logic [PTR_W-1:0]  cmt_slot_reg;
    logic [HIST_W-1:0] sat_sum;
    logic [HIST_W-1:0] ram_rd_data;

    assign commit = cmt_reg;

    mtfc_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (cmt_slot_reg),
        .wr_data (sat_sum),
        .rd_en   (iss_active),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Multiply, scale, accumulate
    // ------------------------------------------------------------------
    mtfc_pkg::rd_ctl_t         rd_ctl_reg;
    logic                      mul_vld_reg;
    mtfc_pkg::tap_t            mul_tap_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      pre_vld_reg;
    mtfc_pkg::tap_t            pre_tap_reg;
    logic signed [PRE_W-1:0]   pre_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [HIST_W-1:0]  last_sum_reg;

    logic signed [HIST_W-1:0]  mul_past;
    logic signed [GAIN_W-1:0]  mul_gain;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  fb_sum;
    logic signed [FB_W-1:0]    fb;
    logic signed [PRE_W-1:0]   pre_next;
    logic signed [TERM_W-1:0]  term;
    logic signed [ACC_W-1:0]   acc_next;

    // Take the previous output from the bypass register; the memory write
    // for it may still be pending
    always_comb begin
        if (!rd_ctl_reg.hit) begin
            mul_past = '0;
        end else if (rd_ctl_reg.fwd) begin
            mul_past = last_sum_reg;
        end else begin
            mul_past = ram_rd_data;
        end
        case (rd_ctl_reg.tap)
            mtfc_pkg::TAP_MAIN:  mul_gain = gain_main_reg;
            mtfc_pkg::TAP_ONE:   mul_gain = gain_tap1_reg;
            mtfc_pkg::TAP_TWO:   mul_gain = gain_tap2_reg;
            mtfc_pkg::TAP_THREE: mul_gain = gain_tap3_reg;
            default:             mul_gain = '0;
        endcase
    end

    assign prod_next = mul_gain * mul_past;

    // Divide by 2^15 truncating toward zero, then add the sample
    assign fb_sum   = prod_reg + (prod_reg[PROD_W-1] ? FB_BIAS : '0);
    assign fb       = fb_sum[PROD_W-1:FRAC_W];
    assign pre_next = {{(PRE_W-SAMPLE_W){cur_sample_reg[SAMPLE_W-1]}}, cur_sample_reg}
                      + {fb[FB_W-1], fb};

    // Arithmetic shift by two, then sum; the main tap opens a new word
    assign term     = pre_reg[PRE_W-1:2];
    assign acc_next = ((pre_tap_reg == mtfc_pkg::TAP_MAIN) ? '0 : acc_reg)
                      + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    assign sat_sum  = mtfc_pkg::saturate(acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ctl_reg  <= '0;
            mul_vld_reg <= 1'b0;
            pre_vld_reg <= 1'b0;
            cmt_reg     <= 1'b0;
        end else begin
            rd_ctl_reg.vld <= iss_active;
            rd_ctl_reg.tap <= iss_tap;
            rd_ctl_reg.hit <= iss_hit;
            rd_ctl_reg.fwd <= iss_fwd;
            mul_vld_reg    <= rd_ctl_reg.vld;
            pre_vld_reg    <= mul_vld_reg;
            cmt_reg        <= pre_vld_reg && (pre_tap_reg == mtfc_pkg::TAP_THREE);
        end
    end

    always_ff @(posedge aclk) begin
        mul_tap_reg <= rd_ctl_reg.tap;
        prod_reg    <= prod_next;
        pre_tap_reg <= mul_tap_reg;
        pre_reg     <= pre_next;
        if (pre_vld_reg) begin
            acc_reg <= acc_next;
        end
        if (pre_vld_reg && pre_tap_reg == mtfc_pkg::TAP_THREE) begin
            cmt_slot_reg <= cur_slot_reg;
        end
        if (commit) begin
            last_sum_reg <= sat_sum;
        end
    end

    // ------------------------------------------------------------------
    // Output buffer: two words, head drives the port
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ob0_reg;
    logic [SAMPLE_W-1:0] ob1_reg;
    logic [SAMPLE_W-1:0] out_word;

    assign out_word = sat_sum[SAMPLE_W-1:0];
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = ob0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg <= '0;
        end else begin
            ob_cnt_reg <= ob_cnt_reg + 2'(commit) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        case ({commit, pop})
            2'b10: begin
                if (ob_cnt_reg == 2'd0) begin
                    ob0_reg <= out_word;
                end else begin
                    ob1_reg <= out_word;
                end
            end
            2'b01: begin
                ob0_reg <= ob1_reg;
            end
            2'b11: begin
                if (ob_cnt_reg == 2'd1) begin
                    ob0_reg <= out_word;
                end else begin
                    ob0_reg <= ob1_reg;
                    ob1_reg <= out_word;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/core/mtfc_checker.sv @@
`timescale 1ns / 1ps

module mtfc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mtfc_pkg::SAMPLE_W-1:0] m_tdata
);

    localparam logic [2:0] OUT_MAX = 3'(mtfc_pkg::MAX_OUTSTANDING);

    logic [2:0] outst_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Words taken in, results not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outst_reg <= '0;
        end else begin
            outst_reg <= outst_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (outst_reg != 3'd0))
        else $error("result delivered with no word outstanding");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        outst_reg <= OUT_MAX)
        else $error("more words outstanding than the buffers hold");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("buffers not empty after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed or dropped");

    a_in_buffer_full: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("input buffer still open after taking a word");

endmodule

bind multi_tap_feedback_comb_core mtfc_checker u_mtfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mtfc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_WORDS = 270;
    localparam int SAT_WORDS    = 280;
    localparam int MAX_PRINTS   = 100;

    localparam longint HIST_MAX = (64'sd1 <<< (HIST_W - 1)) - 1;
    localparam longint HIST_MIN = -(64'sd1 <<< (HIST_W - 1));

    logic                  aclk;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata      = '0;     // [15:0] in_sample
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;               // [15:0] out_sample
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    multi_tap_feedback_comb_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // Filter state mirrored on the testbench side
    logic signed [HIST_W-1:0] out_hist [mtfc_pkg::HISTORY_DEPTH];
    logic [DELAY_W-1:0]       hist_wr_ptr;
    logic signed [GAIN_W-1:0] tap_gain  [NUM_TAPS];
    logic [DELAY_W-1:0]       tap_delay [NUM_TAPS];   // TAP_MAIN entry holds main_delay

    logic [SAMPLE_W-1:0] sample_q [$];     // samples not yet presented
    logic [SAMPLE_W-1:0] filtered_q [$];   // predicted outputs, oldest first
    logic [SAMPLE_W-1:0] out_want;

    int words_queued  = 0;
    int words_taken   = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 20;
    int sink_idle_pct = 20;
    int hold_left     = 0;
    bit hold_request  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_filter_state();
        foreach (out_hist[i]) out_hist[i] = '0;
        hist_wr_ptr = '0;
        foreach (tap_gain[i]) tap_gain[i] = '0;
        foreach (tap_delay[i]) tap_delay[i] = '0;
        tap_delay[TAP_MAIN] = MAIN_DELAY_RST;
    endfunction

    // Output written 'back' words ago; zero when nothing is held there
    function automatic longint hist_back(int unsigned back);
        if (back == 0 || back > mtfc_pkg::HISTORY_DEPTH) begin
            return 0;
        end
        return out_hist[(hist_wr_ptr + mtfc_pkg::HISTORY_DEPTH - back)
                        % mtfc_pkg::HISTORY_DEPTH];
    endfunction

    // Advance the filter by one sample and return the emitted low 16 bits
    function automatic logic [SAMPLE_W-1:0] comb_filter_step(logic [SAMPLE_W-1:0] raw);
        longint smp;
        longint past;
        longint fb;
        longint acc;
        smp = longint'($signed(raw));
        acc = 0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            if (t == TAP_MAIN) begin
                past = hist_back(tap_delay[TAP_MAIN]);
            end else if (tap_delay[t] > tap_delay[TAP_MAIN]) begin
                past = 0;
            end else begin
                past = hist_back(tap_delay[t] + 1);
            end
            // signed division truncates toward zero, the shift floors
            fb = (longint'(tap_gain[t]) * past) / 32768;
            acc += (smp + fb) >>> 2;
        end
        if (acc > HIST_MAX) acc = HIST_MAX;
        if (acc < HIST_MIN) acc = HIST_MIN;
        out_hist[hist_wr_ptr] = acc[HIST_W-1:0];
        hist_wr_ptr++;
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MAIN_DELAY: tap_delay[TAP_MAIN]  = val[DELAY_W-1:0];
            REG_GAIN_MAIN:  tap_gain[TAP_MAIN]   = val;
            REG_GAIN_TAP1:  tap_gain[TAP_ONE]    = val;
            REG_GAIN_TAP2:  tap_gain[TAP_TWO]    = val;
            REG_GAIN_TAP3:  tap_gain[TAP_THREE]  = val;
            REG_DELAY_TAP1: tap_delay[TAP_ONE]   = val[DELAY_W-1:0];
            REG_DELAY_TAP2: tap_delay[TAP_TWO]   = val[DELAY_W-1:0];
            REG_DELAY_TAP3: tap_delay[TAP_THREE] = val[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Present one register write per clock; the last one lands when enable drops
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        apply_reg(idx, val);
    endtask

    task automatic load_config(logic [DELAY_W-1:0] main_d,
                               logic [GAIN_W-1:0] g_main, logic [GAIN_W-1:0] g1,
                               logic [GAIN_W-1:0] g2, logic [GAIN_W-1:0] g3,
                               logic [DELAY_W-1:0] d1, logic [DELAY_W-1:0] d2,
                               logic [DELAY_W-1:0] d3);
        write_reg(REG_MAIN_DELAY, CFG_DATA_W'(main_d));
        write_reg(REG_GAIN_MAIN, g_main);
        write_reg(REG_GAIN_TAP1, g1);
        write_reg(REG_GAIN_TAP2, g2);
        write_reg(REG_GAIN_TAP3, g3);
        write_reg(REG_DELAY_TAP1, CFG_DATA_W'(d1));
        write_reg(REG_DELAY_TAP2, CFG_DATA_W'(d2));
        write_reg(REG_DELAY_TAP3, CFG_DATA_W'(d3));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_sample(logic [SAMPLE_W-1:0] v);
        sample_q.push_back(v);
        words_queued++;
    endtask

    // Block until every queued sample is taken and every output has come back
    task automatic wait_drained();
        while (words_taken != words_queued || filtered_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    // Keep most tap delays near the main delay so both sides of the cutoff show up
    function automatic logic [DELAY_W-1:0] rand_tap_delay(int unsigned main_d);
        if ($urandom_range(0, 3) == 0) begin
            return DELAY_W'($urandom_range(0, 1023));
        end
        return DELAY_W'($urandom_range(0, (main_d + 2 > 1023) ? 1023 : main_d + 2));
    endfunction

    // Sender: take a word on handshake, hold valid until taken, idle at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                filtered_q.push_back(comb_filter_step(s_tdata));
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Compare each output word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                report_error($sformatf("output word %04h with nothing pending", m_tdata));
            end else begin
                out_want = filtered_q.pop_front();
                if (m_tdata !== out_want) begin
                    report_error($sformatf("out_sample got %04h want %04h",
                                           m_tdata, out_want));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned        mag;
        int                 rnd_words;
        int                 run_len;
        int                 phase_idx;
        logic [DELAY_W-1:0] main_d;

        clear_filter_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: all gains zero, so each output is the sample floored to 4
        queue_sample(16'h0000);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'hFFFE);
        queue_sample(16'h0003);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        wait_drained();

        // Main delay one, extreme gains; tap three lies past the main delay
        load_config(10'd1, 16'h7FFF, 16'h8000, 16'h4000, 16'hFFFF, 10'd0, 10'd1, 10'd1023);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h1234);
        queue_sample(16'hFFFF);
        queue_sample(16'h0000);
        wait_drained();

        // Main delay zero: main tap reads nothing, taps two and three exceed it
        load_config(10'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0, 10'd5, 10'd1023);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'hFFFF);
        wait_drained();

        // Longest delays: tap one reaches the full depth, still unwritten history
        load_config(10'd1023, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
                    10'd1023, 10'd1022, 10'd512);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h2345);
        queue_sample(16'hDCBA);
        wait_drained();

        // Gain of minus one on every tap with alternating full-scale input makes
        // the output grow in both directions until it clamps at both bounds.
        // Hold the receiver off meanwhile so the block fills and stalls its input.
        load_config(10'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 10'd0, 10'd0, 10'd0);
        for (int i = 0; i < SAT_WORDS; i++) begin
            mag = 32767 - $urandom_range(0, 63);
            queue_sample((i % 2 == 0) ? SAMPLE_W'(mag) : SAMPLE_W'(0 - mag));
        end
        hold_request = 1'b1;
        wait_drained();

        // Random settings; one phase runs with no idling on either side
        rnd_words = 0;
        phase_idx = 0;
        while (rnd_words < RANDOM_WORDS) begin
            main_d = ($urandom_range(0, 3) == 0) ? DELAY_W'($urandom_range(1, 1023))
                                                 : DELAY_W'($urandom_range(1, 12));
            load_config(main_d, rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                        rand_tap_delay(main_d), rand_tap_delay(main_d),
                        rand_tap_delay(main_d));
            if (phase_idx == 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 20;
                sink_idle_pct = 20;
            end
            run_len = $urandom_range(20, 50);
            for (int i = 0; i < run_len; i++) begin
                queue_sample(rand_sample());
            end
            rnd_words += run_len;
            phase_idx++;
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && filtered_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
